/* src/qoienc_pkg.sv */
package qoienc_pkg;

  localparam int PIX_W      = 32;
  localparam int HASH_W     = 6;
  localparam int IDX_DEPTH  = 64;
  localparam int CHK_MAX    = 5;
  localparam int CHK_LEN_W  = 3;
  localparam int CNT_W      = 4;
  localparam int HDR_LEN    = 14;
  localparam int END_LEN    = 8;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int CFG_ADDR_W = 1;

  localparam logic [5:0]  MAX_RUN    = 6'd62;
  localparam logic [31:0] PREV_RESET = 32'h0000_00FF;

  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hC0;
  localparam logic [7:0] OP_RGB   = 8'hFE;
  localparam logic [7:0] OP_RGBA  = 8'hFF;

  localparam logic [7:0] MAGIC0     = 8'h71;
  localparam logic [7:0] MAGIC1     = 8'h6F;
  localparam logic [7:0] MAGIC2     = 8'h69;
  localparam logic [7:0] MAGIC3     = 8'h66;
  localparam logic [7:0] CHANNELS   = 8'd4;
  localparam logic [7:0] COLORSPACE = 8'd0;
  localparam logic [7:0] END_FINAL  = 8'h01;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [31:0] width;
    logic [31:0] height;
  } hdr_cfg_t;

  // one pixel's worth of output, as decided by the front end
  typedef struct packed {
    logic                          hdr;
    logic                          run_en;
    logic [7:0]                    run_byte;
    logic [CHK_LEN_W-1:0]          chk_len;
    logic [CHK_MAX-1:0][7:0]       chk;
    logic                          eoi;
  } job_t;

  function automatic logic [HASH_W-1:0] hash6(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b, input logic [7:0] a);
    logic [HASH_W-1:0] t;
    t = r[5:0] * 6'd3 + g[5:0] * 6'd5 + b[5:0] * 6'd7 + a[5:0] * 6'd11;
    return t;
  endfunction

endpackage

/* src/qoienc_ram.sv */
module qoienc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/qoienc_front.sv */
module qoienc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,   // red, green, blue, alpha
  input  logic               in_tlast,
  output qoienc_pkg::job_t   job,
  output logic               job_push,
  input  logic               job_full
);
  import qoienc_pkg::*;

  logic [7:0]        in_r, in_g, in_b, in_a;
  logic [HASH_W-1:0] in_hash;
  logic              in_fire;

  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_color_r;
  logic              s1_last_r;
  logic [HASH_W-1:0] s1_hash_r;
  logic              s1_vld_r;
  logic              s1_fwd_r;
  logic [PIX_W-1:0]  s1_fwd_data_r;
  logic              s1_fire;

  logic [PIX_W-1:0]     prev_r, prev_nxt;
  logic [5:0]           run_r, run_nxt;
  logic                 in_run_r, in_run_nxt;
  logic                 hdr_sent_r;
  logic [IDX_DEPTH-1:0] idx_valid_r;

  logic [PIX_W-1:0] ram_q, idx_color;
  logic             idx_we, has_bytes, clear;
  logic [5:0]       rc;
  logic [7:0]       cr, cg, cb, ca, pr, pg, pb, pa;
  logic signed [8:0] dr, dg, db, dr2, dg2, db2, dg32;
  logic signed [9:0] rr, rb, rr8, rb8;
  job_t             job_c;

  assign in_r    = in_tdata[7:0];
  assign in_g    = in_tdata[15:8];
  assign in_b    = in_tdata[23:16];
  assign in_a    = in_tdata[31:24];
  assign in_hash = hash6(in_r, in_g, in_b, in_a);

  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;
  assign s1_fire   = s1_valid_r && (!job_full || !has_bytes);
  assign clear     = s1_fire && s1_last_r;

  qoienc_ram #(.WIDTH(PIX_W), .DEPTH(IDX_DEPTH)) u_index (
    .clk  (clk),
    .we   (s1_fire && idx_we),
    .waddr(s1_hash_r),
    .wdata(s1_color_r),
    .re   (in_fire),
    .raddr(in_hash),
    .rdata(ram_q)
  );

  // the pixel ahead may write the entry being read in the same cycle
  assign idx_color = s1_fwd_r ? s1_fwd_data_r : (s1_vld_r ? ram_q : '0);

  assign cr = s1_color_r[31:24];
  assign cg = s1_color_r[23:16];
  assign cb = s1_color_r[15:8];
  assign ca = s1_color_r[7:0];
  assign pr = prev_r[31:24];
  assign pg = prev_r[23:16];
  assign pb = prev_r[15:8];
  assign pa = prev_r[7:0];

  assign dr   = $signed({1'b0, cr}) - $signed({1'b0, pr});
  assign dg   = $signed({1'b0, cg}) - $signed({1'b0, pg});
  assign db   = $signed({1'b0, cb}) - $signed({1'b0, pb});
  assign dr2  = dr + 9'sd2;
  assign dg2  = dg + 9'sd2;
  assign db2  = db + 9'sd2;
  assign dg32 = dg + 9'sd32;
  assign rr   = 10'(dr) - 10'(dg);
  assign rb   = 10'(db) - 10'(dg);
  assign rr8  = rr + 10'sd8;
  assign rb8  = rb + 10'sd8;

  always_comb begin
    job_c          = '0;
    job_c.hdr      = !hdr_sent_r;
    job_c.eoi      = s1_last_r;
    idx_we         = 1'b0;
    prev_nxt       = prev_r;
    run_nxt        = run_r;
    in_run_nxt     = in_run_r;
    rc             = run_r + 6'd1;
    if (s1_color_r == prev_r) begin
      if (!in_run_r) begin
        idx_we = 1'b1;
        rc     = 6'd1;
      end
      run_nxt    = rc;
      in_run_nxt = 1'b1;
      if (rc == MAX_RUN || s1_last_r) begin
        job_c.run_en   = 1'b1;
        job_c.run_byte = OP_RUN | {2'b00, rc - 6'd1};
        in_run_nxt     = 1'b0;
      end
    end else begin
      prev_nxt = s1_color_r;
      if (in_run_r) begin
        job_c.run_en   = 1'b1;
        job_c.run_byte = OP_RUN | {2'b00, run_r - 6'd1};
        in_run_nxt     = 1'b0;
      end
      if (idx_color == s1_color_r) begin
        job_c.chk_len = 3'd1;
        job_c.chk[0]  = OP_INDEX | {2'b00, s1_hash_r};
      end else begin
        idx_we = 1'b1;
        if (ca == pa) begin
          if (dr >= -9'sd2 && dr <= 9'sd1 && dg >= -9'sd2 && dg <= 9'sd1 &&
              db >= -9'sd2 && db <= 9'sd1) begin
            job_c.chk_len = 3'd1;
            job_c.chk[0]  = OP_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
          end else if (rr >= -10'sd8 && rr <= 10'sd7 && dg >= -9'sd32 && dg <= 9'sd31 &&
                       rb >= -10'sd8 && rb <= 10'sd7) begin
            job_c.chk_len = 3'd2;
            job_c.chk[0]  = OP_LUMA | {2'b00, dg32[5:0]};
            job_c.chk[1]  = {rr8[3:0], rb8[3:0]};
          end else begin
            job_c.chk_len = 3'd4;
            job_c.chk[0]  = OP_RGB;
            job_c.chk[1]  = cr;
            job_c.chk[2]  = cg;
            job_c.chk[3]  = cb;
          end
        end else begin
          job_c.chk_len = 3'd5;
          job_c.chk[0]  = OP_RGBA;
          job_c.chk[1]  = cr;
          job_c.chk[2]  = cg;
          job_c.chk[3]  = cb;
          job_c.chk[4]  = ca;
        end
      end
    end
    has_bytes = job_c.hdr || job_c.run_en || (job_c.chk_len != '0) || job_c.eoi;
  end

  assign job      = job_c;
  assign job_push = s1_fire && has_bytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      prev_r      <= PREV_RESET;
      run_r       <= '0;
      in_run_r    <= 1'b0;
      hdr_sent_r  <= 1'b0;
      idx_valid_r <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        if (s1_last_r) begin
          prev_r      <= PREV_RESET;
          run_r       <= '0;
          in_run_r    <= 1'b0;
          hdr_sent_r  <= 1'b0;
          idx_valid_r <= '0;
        end else begin
          prev_r     <= prev_nxt;
          run_r      <= run_nxt;
          in_run_r   <= in_run_nxt;
          hdr_sent_r <= 1'b1;
          if (idx_we) begin
            idx_valid_r[s1_hash_r] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_color_r    <= {in_r, in_g, in_b, in_a};
      s1_last_r     <= in_tlast;
      s1_hash_r     <= in_hash;
      s1_vld_r      <= !clear && idx_valid_r[in_hash];
      s1_fwd_r      <= !clear && s1_fire && idx_we && (s1_hash_r == in_hash);
      s1_fwd_data_r <= s1_color_r;
    end
  end

endmodule

/* src/qoienc_queue.sv */
module qoienc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  qoienc_pkg::job_t push_data,
  output logic             full,
  input  logic             pop,
  output qoienc_pkg::job_t head,
  output logic             head_valid
);
  import qoienc_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full       = count_r == (QPTR_W + 1)'(QDEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/qoienc_back.sv */
module qoienc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qoienc_pkg::hdr_cfg_t cfg,
  input  qoienc_pkg::job_t     head,
  input  logic                 head_valid,
  output logic                 head_pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // out_byte
  output logic                 out_tlast,  // last_of_item
  output logic                 out_tuser   // image_done
);
  import qoienc_pkg::*;

  typedef enum logic [3:0] {
    PH_HDR = 4'b0001,
    PH_RUN = 4'b0010,
    PH_CHK = 4'b0100,
    PH_END = 4'b1000
  } phase_t;

  phase_t           phase_r, first_ph, eff_ph, next_ph;
  logic [CNT_W-1:0] cnt_r, eff_cnt;
  logic             started_r;
  logic             out_tvalid_r;
  logic [7:0]       out_tdata_r, cur_byte;
  logic             out_tlast_r, out_tuser_r;
  logic             out_free, step, part_end, have_next, last_byte;

  always_comb begin
    if (head.hdr) begin
      first_ph = PH_HDR;
    end else if (head.run_en) begin
      first_ph = PH_RUN;
    end else if (head.chk_len != '0) begin
      first_ph = PH_CHK;
    end else begin
      first_ph = PH_END;
    end
  end

  assign eff_ph  = started_r ? phase_r : first_ph;
  assign eff_cnt = started_r ? cnt_r : '0;

  always_comb begin
    cur_byte  = '0;
    part_end  = 1'b0;
    have_next = 1'b0;
    next_ph   = PH_END;
    unique case (eff_ph)
      PH_HDR: begin
        unique case (eff_cnt)
          4'd0:    cur_byte = MAGIC0;
          4'd1:    cur_byte = MAGIC1;
          4'd2:    cur_byte = MAGIC2;
          4'd3:    cur_byte = MAGIC3;
          4'd4:    cur_byte = cfg.width[31:24];
          4'd5:    cur_byte = cfg.width[23:16];
          4'd6:    cur_byte = cfg.width[15:8];
          4'd7:    cur_byte = cfg.width[7:0];
          4'd8:    cur_byte = cfg.height[31:24];
          4'd9:    cur_byte = cfg.height[23:16];
          4'd10:   cur_byte = cfg.height[15:8];
          4'd11:   cur_byte = cfg.height[7:0];
          4'd12:   cur_byte = CHANNELS;
          default: cur_byte = COLORSPACE;
        endcase
        part_end = eff_cnt == CNT_W'(HDR_LEN - 1);
        if (head.run_en) begin
          have_next = 1'b1;
          next_ph   = PH_RUN;
        end else if (head.chk_len != '0) begin
          have_next = 1'b1;
          next_ph   = PH_CHK;
        end else begin
          have_next = head.eoi;
        end
      end
      PH_RUN: begin
        cur_byte = head.run_byte;
        part_end = 1'b1;
        if (head.chk_len != '0) begin
          have_next = 1'b1;
          next_ph   = PH_CHK;
        end else begin
          have_next = head.eoi;
        end
      end
      PH_CHK: begin
        unique case (eff_cnt)
          4'd0:    cur_byte = head.chk[0];
          4'd1:    cur_byte = head.chk[1];
          4'd2:    cur_byte = head.chk[2];
          4'd3:    cur_byte = head.chk[3];
          default: cur_byte = head.chk[4];
        endcase
        part_end  = eff_cnt == ({1'b0, head.chk_len} - 4'd1);
        have_next = head.eoi;
      end
      PH_END: begin
        part_end = eff_cnt == CNT_W'(END_LEN - 1);
        cur_byte = part_end ? END_FINAL : 8'h00;
      end
      default: begin
        cur_byte = '0;
      end
    endcase
  end

  assign last_byte = part_end && !have_next;
  assign out_free  = !out_tvalid_r || out_tready;
  assign step      = head_valid && out_free;
  assign head_pop  = step && last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (step) begin
        out_tvalid_r <= 1'b1;
        if (last_byte) begin
          started_r <= 1'b0;
        end else begin
          started_r <= 1'b1;
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_tdata_r <= cur_byte;
      out_tlast_r <= last_byte;
      out_tuser_r <= (eff_ph == PH_END) && part_end;
      if (part_end) begin
        phase_r <= next_ph;
        cnt_r   <= '0;
      end else begin
        phase_r <= eff_ph;
        cnt_r   <= eff_cnt + 1'b1;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

endmodule

/* src/qoi_image_encoder.sv */
// path: front stage register, then job queue, then the back end's output register
// throughput: one pixel per cycle in while the queue has room, one byte per cycle out
//   while out_tready is high; the sequencer sets the sustained rate, 0 to 27 bytes a pixel
// reset: rst_n synchronous, active low; clears the hash index valid bits, run state,
//   queue and output register at once, no clearing pass; width and height reset to 1
module qoi_image_encoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // red, green, blue, alpha
  input  logic                              in_tlast,   // last_pixel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // out_byte
  output logic                              out_tlast,  // last_of_item
  output logic                              out_tuser,  // image_done
  input  logic                              cfg_we,
  input  logic [qoienc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]                       cfg_wdata
);
  import qoienc_pkg::*;

  hdr_cfg_t cfg_r;
  job_t     front_job, head;
  logic     job_push, job_full, head_valid, head_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= 32'd1;
      cfg_r.height <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WIDTH:  cfg_r.width  <= cfg_wdata;
        REG_HEIGHT: cfg_r.height <= cfg_wdata;
        default:    cfg_r.width  <= cfg_r.width;
      endcase
    end
  end

  qoienc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .job      (front_job),
    .job_push (job_push),
    .job_full (job_full)
  );

  qoienc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (front_job),
    .full      (job_full),
    .pop       (head_pop),
    .head      (head),
    .head_valid(head_valid)
  );

  qoienc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .head_valid(head_valid),
    .head_pop  (head_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == END_FINAL)
    else $error("image end beat is not the last byte of its pixel");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_push && job_full))
    else $error("job queue written while full");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> head_valid)
    else $error("job queue popped while empty");

  a_push_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> front_job.hdr || front_job.run_en || front_job.chk_len != '0 ||
                 front_job.eoi)
    else $error("empty job pushed");
`endif

endmodule
